// ----- hdl/wsfd_pkg.sv -----
// wsfd_pkg: shared types and constants for the websocket frame decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package wsfd_pkg;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOT_FIN = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length byte counts, minus one
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic [7:0] data;
  } res_t;

endpackage

// ----- hdl/wsfd_in_reg.sv -----
// wsfd_in_reg: input register stage of the websocket frame decoder
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_in_reg
  import wsfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  room,
  output logic  adv,
  output item_t item
);

  logic  vld_r, vld_nxt;
  item_t item_r;

  // a held word moves on when the result register has space
  assign adv      = vld_r && room;
  assign in_ready = !vld_r || adv;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hdl/wsfd_core.sv -----
// wsfd_core: header parser state and payload unmasking
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_core
  import wsfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  item_t  item,
  output logic   res_vld,
  output res_t   res,
  output phase_t phase
);

  phase_t      phase_r, phase_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  ext_r, ext_nxt;
  logic [31:0] key_r, key_nxt;
  logic        mask_r, mask_nxt;
  logic [1:0]  kp_r, kp_nxt;

  logic [7:0]  b;
  logic [63:0] rem_shift;
  logic [7:0]  kbyte;
  logic        emit;
  res_t        r;

  assign b         = item.data;
  assign rem_shift = {rem_r[55:0], b};
  assign phase     = phase_r;

  always_comb begin
    case (kp_r)
      2'd0:    kbyte = key_r[31:24];
      2'd1:    kbyte = key_r[23:16];
      2'd2:    kbyte = key_r[15:8];
      default: kbyte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    ext_nxt   = ext_r;
    key_nxt   = key_r;
    mask_nxt  = mask_r;
    kp_nxt    = kp_r;
    emit      = 1'b0;
    r         = '{status: ST_PAYLOAD, last: 1'b1, data: 8'd0};

    case (phase_r)
      PH_FIRST: begin
        if (!b[7]) begin
          phase_nxt = PH_SKIP;
          emit      = 1'b1;
          r.status  = ST_NOT_FIN;
        end else begin
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        mask_nxt = b[7];
        key_nxt  = '0;
        kp_nxt   = 2'd0;
        if (b[6:0] == LEN_EXT16) begin
          rem_nxt   = '0;
          ext_nxt   = EXT16_CNT;
          phase_nxt = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          rem_nxt   = '0;
          ext_nxt   = EXT64_CNT;
          phase_nxt = PH_EXT;
        end else begin
          rem_nxt = {57'd0, b[6:0]};
          if (b[7]) begin
            phase_nxt = PH_KEY;
          end else if (b[6:0] == 7'd0) begin
            phase_nxt = PH_SKIP;
            emit      = 1'b1;
            r.status  = ST_EMPTY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_EXT: begin
        rem_nxt = rem_shift;
        if (ext_r == 3'd0) begin
          kp_nxt = 2'd0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else if (rem_shift == 64'd0) begin
            phase_nxt = PH_SKIP;
            emit      = 1'b1;
            r.status  = ST_EMPTY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          ext_nxt = ext_r - 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], b};
        kp_nxt  = kp_r + 2'd1;
        if (kp_r == 2'd3) begin
          if (rem_r == 64'd0) begin
            phase_nxt = PH_SKIP;
            emit      = 1'b1;
            r.status  = ST_EMPTY;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kp_nxt  = kp_r + 2'd1;
        rem_nxt = rem_r - 64'd1;
        emit    = 1'b1;
        r.data  = mask_r ? (b ^ kbyte) : b;
        if (rem_r == 64'd1) begin
          phase_nxt = PH_SKIP;
        end else begin
          r.last = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // end of buffer: flag an unfinished frame, then start over
    if (item.last) begin
      if (phase_nxt inside {PH_SECOND, PH_EXT, PH_KEY, PH_PAYLOAD}) begin
        emit = 1'b1;
        r    = '{status: ST_TRUNC, last: 1'b1, data: 8'd0};
      end
      phase_nxt = PH_FIRST;
      rem_nxt   = '0;
      ext_nxt   = '0;
      key_nxt   = '0;
      mask_nxt  = 1'b0;
      kp_nxt    = 2'd0;
    end
  end

  assign res_vld = adv && emit;
  assign res     = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      rem_r   <= '0;
      ext_r   <= '0;
      key_r   <= '0;
      mask_r  <= 1'b0;
      kp_r    <= 2'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      ext_r   <= ext_nxt;
      key_r   <= key_nxt;
      mask_r  <= mask_nxt;
      kp_r    <= kp_nxt;
    end
  end

endmodule

// ----- hdl/wsfd_out_reg.sv -----
// wsfd_out_reg: result register of the websocket frame decoder
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_out_reg
  import wsfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_vld,
  input  res_t res,
  output logic room,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic vld_r, vld_nxt;
  res_t res_r;

  // space when empty or the held word leaves this cycle
  assign room      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (room) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (room && res_vld) begin
      res_r <= res;
    end
  end

endmodule

// ----- hdl/websocket_frame_decoder.sv -----
// websocket_frame_decoder: top level, byte-wide websocket frame header parser and unmasker
// depends on wsfd_pkg, wsfd_in_reg, wsfd_core, wsfd_out_reg
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tdata[7:0] raw byte, tlast end of buffer
//  out_     out  out_tvalid/out_tready tdata[7:0] byte, tlast last, tuser[1:0] status
//
// one byte per clock unless out_tready stalls; input register, then result register
// each byte gives at most one word; header bytes give only status words, trailing bytes none
// rst_n is synchronous, active low, and returns the parser to the first header byte
// a stalled result register holds the input register, which then drops in_tready
`timescale 1ns / 1ps

module websocket_frame_decoder
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_buffer
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last
  output logic [1:0] out_tuser   // [1:0] status
);

  item_t  in_item;
  item_t  item;
  logic   adv;
  logic   room;
  logic   res_vld;
  res_t   res;
  res_t   out_res;
  phase_t phase;

  assign in_item = '{last: in_tlast, data: in_tdata};

  wsfd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .room     (room),
    .adv      (adv),
    .item     (item)
  );

  wsfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .item    (item),
    .res_vld (res_vld),
    .res     (res),
    .phase   (phase)
  );

  wsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.status;

`ifndef SYNTHESIS
  // status-only words carry a zero byte and always close
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_PAYLOAD) |-> out_tlast && (out_tdata == 8'd0))
    else $error("status word without last or with data");

  // end of buffer always brings the parser back to the first header byte
  a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.last |=> phase == PH_FIRST)
    else $error("parser not restarted after end of buffer");

  // a result is only produced when the result register can take it
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> room)
    else $error("result produced without space");

  // an accepted word is held in the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> adv || !room)
    else $error("accepted word lost");
`endif

endmodule
